@@ design/two_channel_hit_detector_unit_defines.svh @@
// Assertion helpers for the hit detector.
`ifndef TWO_CHANNEL_HIT_DETECTOR_UNIT_DEFINES_SVH
`define TWO_CHANNEL_HIT_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define HD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define HD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/hd_pkg.sv @@
package hd_pkg;

  localparam int NUM_CHANNELS        = 2;
  localparam int SAMPLE_BITS_DEFAULT = 12;
  localparam int TIME_BITS_DEFAULT   = 48;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int PRE_BITS       = 16;

  // Thresholds keep enough bits for their reset values at any sample width.
  localparam int RESET_THR_BITS   = 10;
  localparam int START_THR_RESET  = 1000;
  localparam int END_THR_RESET    = 500;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_CH0 = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET_CH1 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_THR  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_END_THR    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PRE_SAMPLES = 3'd4;

  function automatic int thr_bits(input int sample_bits);
    return (sample_bits > RESET_THR_BITS) ? sample_bits : RESET_THR_BITS;
  endfunction

endpackage

@@ design/hd_cfg_if.sv @@
interface hd_cfg_if;
  import hd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/hd_sample_if.sv @@
interface hd_sample_if #(
  parameter int SAMPLE_BITS = hd_pkg::SAMPLE_BITS_DEFAULT
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

@@ design/hd_hit_if.sv @@
interface hd_hit_if #(
  parameter int SAMPLE_BITS = hd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int TIME_BITS   = hd_pkg::TIME_BITS_DEFAULT
);
  logic                        valid;
  logic                        ready;
  logic                        hit_channel;
  logic [SAMPLE_BITS-1:0]      peak_value;
  logic signed [TIME_BITS:0]   start_time;
  logic [TIME_BITS-1:0]        end_time;
  logic [TIME_BITS-1:0]        integral_halves;

  modport source (output valid, output hit_channel, output peak_value, output start_time,
                  output end_time, output integral_halves, input ready);
  modport sink (input valid, input hit_channel, input peak_value, input start_time,
                input end_time, input integral_halves, output ready);
endinterface

@@ design/two_channel_hit_detector_unit.sv @@
// A sample is held in the input register; a sample that ends a hit then loads
//   its hit item into the result register, valid on the hit channel from there.
// Throughput: one sample per cycle, set by the single per-channel update stage.
// Stalls on the hit channel hold only samples that end a hit.
// Reset (rst, synchronous): clears all hit state, time and phase (channel 0
//   next), offsets and pre-samples to zero, thresholds to 1000 and 500.
`include "two_channel_hit_detector_unit_defines.svh"

module two_channel_hit_detector_unit #(
  parameter int SAMPLE_BITS = hd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int TIME_BITS   = hd_pkg::TIME_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  hd_cfg_if.sink     cfg,
  hd_sample_if.sink  samples,
  hd_hit_if.source   hits
);
  import hd_pkg::*;

  localparam int THR_BITS = thr_bits(SAMPLE_BITS);

  logic [SAMPLE_BITS-1:0] offset_ch0;
  logic [SAMPLE_BITS-1:0] offset_ch1;
  logic [THR_BITS-1:0]    start_thr;
  logic [THR_BITS-1:0]    end_thr;
  logic [PRE_BITS-1:0]    pre_samples;

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_raw;
  logic                   phase;
  logic [TIME_BITS-1:0]   sample_index;

  logic [SAMPLE_BITS-1:0] offset;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   out_free;
  logic                   fire;
  logic                   s1_go;

  logic [NUM_CHANNELS-1:0] take;
  logic [NUM_CHANNELS-1:0] hit_end;
  logic [SAMPLE_BITS-1:0]  peak_next   [NUM_CHANNELS];
  logic [TIME_BITS-1:0]    start_index [NUM_CHANNELS];
  logic [TIME_BITS-1:0]    integ_next  [NUM_CHANNELS];

  hd_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .THR_BITS    (THR_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .offset_ch0  (offset_ch0),
    .offset_ch1  (offset_ch1),
    .start_thr   (start_thr),
    .end_thr     (end_thr),
    .pre_samples (pre_samples)
  );

  assign offset   = phase ? offset_ch1 : offset_ch0;
  assign sample   = (s1_raw < offset) ? '0 : s1_raw - offset;
  assign out_free = !hits.valid || hits.ready;
  assign fire     = s1_valid && hit_end[phase];
  assign s1_go    = s1_valid && (!fire || out_free);
  assign take     = {s1_go && phase, s1_go && !phase};

  assign samples.ready = !s1_valid || s1_go;

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    hd_chan_track #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS),
      .THR_BITS    (THR_BITS)
    ) u_track (
      .clk           (clk),
      .rst           (rst),
      .take          (take[c]),
      .sample        (sample),
      .sample_index  (sample_index),
      .start_thr     (start_thr),
      .end_thr       (end_thr),
      .hit_end       (hit_end[c]),
      .peak_next     (peak_next[c]),
      .start_index   (start_index[c]),
      .integral_next (integ_next[c])
    );
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_raw <= samples.raw_sample;
    end
  end

  // phase advances per processed item, time after each channel 1 item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 1'b0;
      sample_index <= '0;
    end else if (s1_go) begin
      phase <= !phase;
      if (phase) begin
        sample_index <= sample_index + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      hits.valid <= 1'b0;
    end else if (s1_go && fire) begin
      hits.valid <= 1'b1;
    end else if (hits.ready) begin
      hits.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && fire) begin
      hits.hit_channel     <= phase;
      hits.peak_value      <= peak_next[phase];
      hits.start_time      <= {1'b0, start_index[phase]} - (TIME_BITS + 1)'(pre_samples);
      hits.end_time        <= sample_index;
      hits.integral_halves <= integ_next[phase];
    end
  end

  `HD_ASSERT_NEXT(a_phase_toggles, clk, rst, s1_go, phase != $past(phase), "phase did not toggle")
  `HD_ASSERT_NEXT(a_index_steps, clk, rst, s1_go && phase, sample_index == TIME_BITS'($past(sample_index) + 1'b1), "index did not advance")
  `HD_ASSERT_NOW(a_result_source, clk, rst, $rose(hits.valid), $past(s1_go && fire), "result without hit end")
  `HD_ASSERT_NOW(a_ready_only_full, clk, rst, !samples.ready, s1_valid, "stall with empty input register")

endmodule

@@ design/hd_cfg_regs.sv @@
module hd_cfg_regs #(
  parameter int SAMPLE_BITS = hd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int THR_BITS    = hd_pkg::thr_bits(hd_pkg::SAMPLE_BITS_DEFAULT)
) (
  input  logic                          clk,
  input  logic                          rst,
  hd_cfg_if.sink                        cfg,
  output logic [SAMPLE_BITS-1:0]        offset_ch0,
  output logic [SAMPLE_BITS-1:0]        offset_ch1,
  output logic [THR_BITS-1:0]           start_thr,
  output logic [THR_BITS-1:0]           end_thr,
  output logic [hd_pkg::PRE_BITS-1:0]   pre_samples
);
  import hd_pkg::*;

  logic                   wr;
  logic [THR_BITS-1:0]    wr_thr;

  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;
  assign wr_thr    = THR_BITS'(cfg.data[SAMPLE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_ch0  <= '0;
      offset_ch1  <= '0;
      start_thr   <= THR_BITS'(START_THR_RESET);
      end_thr     <= THR_BITS'(END_THR_RESET);
      pre_samples <= '0;
    end else if (wr) begin
      case (cfg.index)
        CFG_OFFSET_CH0:  offset_ch0  <= cfg.data[SAMPLE_BITS-1:0];
        CFG_OFFSET_CH1:  offset_ch1  <= cfg.data[SAMPLE_BITS-1:0];
        CFG_START_THR:   start_thr   <= wr_thr;
        CFG_END_THR:     end_thr     <= wr_thr;
        CFG_PRE_SAMPLES: pre_samples <= cfg.data[PRE_BITS-1:0];
        default: ;
      endcase
    end
  end
endmodule

@@ design/hd_chan_track.sv @@
module hd_chan_track #(
  parameter int SAMPLE_BITS = hd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int TIME_BITS   = hd_pkg::TIME_BITS_DEFAULT,
  parameter int THR_BITS    = hd_pkg::thr_bits(hd_pkg::SAMPLE_BITS_DEFAULT)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [TIME_BITS-1:0]   sample_index,
  input  logic [THR_BITS-1:0]    start_thr,
  input  logic [THR_BITS-1:0]    end_thr,
  output logic                   hit_end,
  output logic [SAMPLE_BITS-1:0] peak_next,
  output logic [TIME_BITS-1:0]   start_index,
  output logic [TIME_BITS-1:0]   integral_next
);
  logic                   in_hit;
  logic [SAMPLE_BITS-1:0] prev_sample;
  logic [SAMPLE_BITS-1:0] peak;
  logic [TIME_BITS-1:0]   integral;
  logic [THR_BITS-1:0]    sample_ext;
  logic [SAMPLE_BITS:0]   pair_sum;
  logic [TIME_BITS:0]     acc_sum;
  logic                   starts;

  assign sample_ext = THR_BITS'(sample);
  assign starts     = !in_hit && (sample_ext > start_thr);
  assign hit_end    = in_hit && (sample_ext < end_thr);

  // trapezoid step in half-LSB units, saturating
  assign pair_sum      = {1'b0, prev_sample} + {1'b0, sample};
  assign acc_sum       = {1'b0, integral} + (TIME_BITS + 1)'(pair_sum);
  assign integral_next = acc_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : acc_sum[TIME_BITS-1:0];
  assign peak_next     = (sample > peak) ? sample : peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_hit      <= 1'b0;
      prev_sample <= '0;
      peak        <= '0;
      integral    <= '0;
      start_index <= '0;
    end else if (take) begin
      prev_sample <= sample;
      if (starts) begin
        in_hit      <= 1'b1;
        start_index <= sample_index;
        peak        <= sample;
        integral    <= '0;
      end else if (in_hit) begin
        integral <= integral_next;
        peak     <= peak_next;
        if (hit_end) begin
          in_hit <= 1'b0;
        end
      end
    end
  end
endmodule
